### rtl/core/olar_pkg.sv
// ----------------------------------------------------------------------------
// olar_pkg: shared definitions for the ordered list unit
// Request and status codes, field widths and the result word handed from the
// sequencer to the output stage.
// ----------------------------------------------------------------------------
package olar_pkg;

  localparam int OLAR_CAPACITY = 32;
  localparam int REQ_W         = 2;
  localparam int VAL_W         = 32;
  localparam int STAT_W        = 3;

  localparam logic [REQ_W-1:0] REQ_APPEND = 2'd0;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LIST   = 2'd2;

  localparam logic [STAT_W-1:0] ST_ADDED    = 3'd0;
  localparam logic [STAT_W-1:0] ST_REMOVED  = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd2;
  localparam logic [STAT_W-1:0] ST_FULL     = 3'd3;
  localparam logic [STAT_W-1:0] ST_ELEMENT  = 3'd4;
  localparam logic [STAT_W-1:0] ST_EMPTY    = 3'd5;

  typedef struct packed {
    logic                    valid;
    logic [STAT_W-1:0]       status;
    logic signed [VAL_W-1:0] value;
    logic                    last;
  } olar_emit_t;

endpackage

### rtl/core/olar_req_if.sv
// ----------------------------------------------------------------------------
// olar_req_if: request channel
// Valid/ready channel that carries one request word.
// ----------------------------------------------------------------------------
interface olar_req_if import olar_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [REQ_W-1:0]        req_type;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, req_type, value, input ready);
  modport sink (input valid, req_type, value, output ready);
endinterface

### rtl/core/olar_rsp_if.sv
// ----------------------------------------------------------------------------
// olar_rsp_if: result channel
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface olar_rsp_if import olar_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [STAT_W-1:0]       status;
  logic signed [VAL_W-1:0] item_value;
  logic                    last;

  modport source (output valid, status, item_value, last, input ready);
  modport sink (input valid, status, item_value, last, output ready);
endinterface

### rtl/core/olar_ram.sv
// ----------------------------------------------------------------------------
// olar_ram: generic simple dual-port RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
module olar_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### rtl/core/olar_out_stage.sv
// ----------------------------------------------------------------------------
// olar_out_stage: result output register
// Holds one result word so the sequencer can keep working while it waits.
// ----------------------------------------------------------------------------
module olar_out_stage import olar_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  olar_emit_t  emit,
  output logic        out_free,
  olar_rsp_if.source  out_rsp
);

  logic                    valid_r, valid_nxt;
  logic [STAT_W-1:0]       status_r;
  logic signed [VAL_W-1:0] value_r;
  logic                    last_r;

  assign out_free = !valid_r || out_rsp.ready;

  always_comb begin
    valid_nxt = valid_r;
    if (out_rsp.ready) begin
      valid_nxt = 1'b0;
    end
    if (emit.valid) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (emit.valid && out_free) begin
      status_r <= emit.status;
      value_r  <= emit.value;
      last_r   <= emit.last;
    end
  end

  assign out_rsp.valid      = valid_r;
  assign out_rsp.status     = status_r;
  assign out_rsp.item_value = value_r;
  assign out_rsp.last       = last_r;

endmodule

### rtl/core/olar_seq.sv
// ----------------------------------------------------------------------------
// olar_seq: list sequencer
// Walks the entry store one entry a cycle, a listing only while out_free is
// high, with a single comparator to search, close gaps and stream the list.
// ----------------------------------------------------------------------------
module olar_seq import olar_pkg::*; #(
  parameter int CAPACITY = OLAR_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  olar_req_if.sink                    in_req,
  output olar_emit_t                  emit,
  input  logic                        out_free,
  output logic                        ram_wr_en,
  output logic [$clog2(CAPACITY)-1:0] ram_wr_addr,
  output logic [VAL_W-1:0]            ram_wr_data,
  output logic                        ram_rd_en,
  output logic [$clog2(CAPACITY)-1:0] ram_rd_addr,
  input  logic [VAL_W-1:0]            ram_rd_data
);

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_C = CNT_W'(1);
  localparam logic [CNT_W-1:0] TWO_C = CNT_W'(2);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_SEARCH = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_LIST   = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic [STAT_W-1:0] resp_r, resp_nxt;
  logic [CNT_W-1:0]  idx_p1;
  logic [CNT_W-1:0]  idx_p2;
  logic [CNT_W-1:0]  rd_idx;
  logic              hit;
  logic              accept;

  assign idx_p1      = idx_r + ONE_C;
  assign idx_p2      = idx_r + TWO_C;
  assign hit         = (ram_rd_data == value_r);
  assign in_req.ready = (state_r == S_IDLE);
  assign accept      = in_req.valid && in_req.ready;
  assign ram_rd_addr = rd_idx[AW-1:0];

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    idx_nxt     = idx_r;
    value_nxt   = value_r;
    resp_nxt    = resp_r;
    ram_wr_en   = 1'b0;
    ram_wr_addr = count_r[AW-1:0];
    ram_wr_data = in_req.value;
    ram_rd_en   = 1'b0;
    rd_idx      = '0;
    emit        = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          value_nxt = in_req.value;
          idx_nxt   = '0;
          case (in_req.req_type)
            REQ_APPEND: begin
              state_nxt = S_RESP;
              if (count_r == CAP_C) begin
                resp_nxt = ST_FULL;
              end else begin
                resp_nxt  = ST_ADDED;
                ram_wr_en = 1'b1;
                count_nxt = count_r + ONE_C;
              end
            end
            REQ_REMOVE: begin
              if (count_r == '0) begin
                resp_nxt  = ST_NOTFOUND;
                state_nxt = S_RESP;
              end else begin
                ram_rd_en = 1'b1;
                state_nxt = S_SEARCH;
              end
            end
            REQ_LIST: begin
              if (count_r == '0) begin
                resp_nxt  = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                ram_rd_en = 1'b1;
                state_nxt = S_LIST;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_SEARCH: begin
        rd_idx = idx_p1;
        if (idx_p1 == count_r) begin
          state_nxt = S_RESP;
          if (hit) begin
            resp_nxt  = ST_REMOVED;
            count_nxt = count_r - ONE_C;
          end else begin
            resp_nxt = ST_NOTFOUND;
          end
        end else begin
          ram_rd_en = 1'b1;
          if (hit) begin
            state_nxt = S_SHIFT;
          end else begin
            idx_nxt = idx_p1;
          end
        end
      end
      S_SHIFT: begin
        ram_wr_en   = 1'b1;
        ram_wr_addr = idx_r[AW-1:0];
        ram_wr_data = ram_rd_data;
        rd_idx      = idx_p2;
        if (idx_p2 == count_r) begin
          resp_nxt  = ST_REMOVED;
          count_nxt = count_r - ONE_C;
          state_nxt = S_RESP;
        end else begin
          ram_rd_en = 1'b1;
          idx_nxt   = idx_p1;
        end
      end
      S_LIST: begin
        rd_idx = idx_p1;
        if (out_free) begin
          emit.valid  = 1'b1;
          emit.status = ST_ELEMENT;
          emit.value  = ram_rd_data;
          emit.last   = (idx_p1 == count_r);
          if (idx_p1 == count_r) begin
            state_nxt = S_IDLE;
          end else begin
            ram_rd_en = 1'b1;
            idx_nxt   = idx_p1;
          end
        end
      end
      S_RESP: begin
        if (out_free) begin
          emit.valid  = 1'b1;
          emit.status = resp_r;
          emit.value  = value_r;
          emit.last   = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
    idx_r   <= idx_nxt;
    value_r <= value_nxt;
    resp_r  <= resp_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_C)
    else $error("Entry count exceeds capacity.");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_req.req_type == REQ_APPEND && count_r != CAP_C)
    |=> count_r == $past(count_r) + ONE_C)
    else $error("Accepted append did not grow the list.");

  a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SEARCH || state_r == S_SHIFT || state_r == S_LIST)
    |-> idx_r < count_r)
    else $error("Walk index ran past the stored entries.");

  a_shift_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (idx_p1 < count_r))
    else $error("Gap closing moved an entry from outside the list.");

endmodule

### rtl/core/ordered_list_append_remove_unit.sv
// ----------------------------------------------------------------------------
// ordered_list_append_remove_unit: bounded ordered list of signed values
// Appends at the tail, removes the first equal entry and lists all entries.
//
//   channel  direction  words per request
//   in_req   input      one request word
//   out_rsp  output     one result word, or one per entry for a listing
//
// A remove reads the store one entry a cycle through its single read port
// and comparator, then moves each later entry down one place. Reset clears
// the state, the entry count and the output valid flag; the store is not
// swept. A stalled result waits in the output register, and a listing
// pauses until that register frees up.
// ----------------------------------------------------------------------------
module ordered_list_append_remove_unit import olar_pkg::*; #(
  parameter int CAPACITY = OLAR_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  olar_req_if.sink   in_req,
  olar_rsp_if.source out_rsp
);

  localparam int AW = $clog2(CAPACITY);

  olar_emit_t       emit;
  logic             out_free;
  logic             ram_wr_en;
  logic [AW-1:0]    ram_wr_addr;
  logic [VAL_W-1:0] ram_wr_data;
  logic             ram_rd_en;
  logic [AW-1:0]    ram_rd_addr;
  logic [VAL_W-1:0] ram_rd_data;

  olar_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (in_req),
    .emit        (emit),
    .out_free    (out_free),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  olar_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  olar_out_stage u_out (
    .clk      (clk),
    .rst_n    (rst_n),
    .emit     (emit),
    .out_free (out_free),
    .out_rsp  (out_rsp)
  );

endmodule
